// ===== hw/rtl/vumph_pkg.sv =====
`default_nettype none

package vumph_pkg;

   localparam int Q_W = 16;

   localparam int          ONE_Q        = 65535;
   localparam logic [15:0] GAIN_DECAY_K = 16'd65470;
   localparam logic [15:0] PEAK_DECAY_K = 16'd63570;
   localparam logic [15:0] GAIN_FLOOR   = 16'd655;

   // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for x < 2**22
   localparam logic [19:0] RECIP10     = 20'd838861;
   localparam int          RECIP_SHIFT = 23;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   localparam int   CSR_AW     = 3;
   localparam logic CSR_SPEED  = 1'b0;
   localparam logic CSR_BRIGHT = 1'b1;

   typedef struct packed {
      logic [Q_W-1:0] level;
      logic [Q_W-1:0] peak;
   } level_pair_type;

   function automatic logic [7:0] full_scale(input logic [2:0] b);
      logic [10:0] p;
      p = 11'(b) * 11'd255;
      if (b > 3'd4) begin
         return 8'hff;
      end
      return p[9:2];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vumph_front.sv =====
`default_nettype none

module vumph_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_audio_present,
   input  wire logic [vumph_pkg::Q_W-1:0]   req_energy,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [vumph_pkg::Q_W-1:0]        out_energy
);

   logic [vumph_pkg::Q_W-1:0]    mem_ff [vumph_pkg::QUEUE_DEPTH];
   logic [vumph_pkg::QUEUE_AW-1:0] wr_ptr_ff;
   logic [vumph_pkg::QUEUE_AW-1:0] rd_ptr_ff;
   logic [vumph_pkg::QUEUE_AW:0]   count_ff;
   logic [vumph_pkg::Q_W-1:0]    energy_in;
   logic                         push;
   logic                         pop;

   // absent audio counts as zero energy
   assign energy_in = req_audio_present ? req_energy : '0;

   assign req_ready  = (count_ff != (vumph_pkg::QUEUE_AW+1)'(vumph_pkg::QUEUE_DEPTH));
   assign out_valid  = (count_ff != '0);
   assign out_energy = mem_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= energy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (vumph_pkg::QUEUE_AW+1)'(vumph_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== hw/rtl/vumph_level.sv =====
`default_nettype none

module vumph_level #(
   parameter int HOLD_FRAMES = 15
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [2:0]                  speed,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [vumph_pkg::Q_W-1:0]   in_energy,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output vumph_pkg::level_pair_type        out_pair
);

   typedef enum logic [2:0] {
      S_IDLE, S_GAIN, S_DIV, S_SMUL, S_SDIV, S_SAPPLY, S_PDEC, S_OUT
   } state_type;

   state_type    state_ff;
   logic [15:0]  gain_ff;
   logic [15:0]  level_ff;
   logic [15:0]  peak_ff;
   logic [3:0]   hold_ff;
   logic [15:0]  t_ff;
   logic [31:0]  gain_prod_ff;
   logic [15:0]  rem_ff;
   logic [15:0]  sh_ff;
   logic [3:0]   cnt_ff;
   logic [18:0]  mag_ff;
   logic         neg_ff;
   logic [38:0]  recip_ff;

   logic [15:0]  raised;
   logic [15:0]  gain_dec;
   logic [15:0]  gain_floor;
   logic [31:0]  numer;
   logic [16:0]  trial;
   logic         qbit;
   logic [16:0]  diff;
   logic [15:0]  abs_diff;
   logic [2:0]   coef;
   logic [15:0]  step;
   logic [15:0]  level_new;
   logic [31:0]  peak_prod;

   assign raised     = (in_energy > gain_ff) ? in_energy : gain_ff;
   assign gain_dec   = gain_prod_ff[31:16];
   assign gain_floor = (gain_dec < vumph_pkg::GAIN_FLOOR) ? vumph_pkg::GAIN_FLOOR : gain_dec;
   assign numer      = {t_ff, 16'h0000} - {16'h0000, t_ff};
   assign trial      = {rem_ff, sh_ff[15]};
   assign qbit       = (trial >= {1'b0, gain_ff});
   assign diff       = {1'b0, sh_ff} - {1'b0, level_ff};
   assign abs_diff   = diff[16] ? 16'(-diff) : diff[15:0];
   assign coef       = 3'd7 - speed;
   assign step       = recip_ff[vumph_pkg::RECIP_SHIFT +: 16];
   assign level_new  = neg_ff ? (level_ff - step) : (level_ff + step);
   assign peak_prod  = 32'(peak_ff) * 32'(vumph_pkg::PEAK_DECAY_K);

   assign in_ready       = (state_ff == S_IDLE);
   assign out_valid      = (state_ff == S_OUT);
   assign out_pair.level = level_ff;
   assign out_pair.peak  = peak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gain_ff  <= '0;
         level_ff <= '0;
         peak_ff  <= '0;
         hold_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  t_ff         <= in_energy;
                  gain_prod_ff <= 32'(raised) * 32'(vumph_pkg::GAIN_DECAY_K);
                  state_ff     <= S_GAIN;
               end
            end
            S_GAIN: begin
               gain_ff <= gain_floor;
               // quotient saturates once energy reaches the gain peak
               if (t_ff >= gain_floor) begin
                  sh_ff    <= 16'hffff;
                  state_ff <= S_SMUL;
               end else begin
                  rem_ff   <= numer[31:16];
                  sh_ff    <= numer[15:0];
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= qbit ? 16'(trial - {1'b0, gain_ff}) : trial[15:0];
               sh_ff  <= {sh_ff[14:0], qbit};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 4'd15) begin
                  state_ff <= S_SMUL;
               end
            end
            S_SMUL: begin
               mag_ff   <= 19'(abs_diff) * 19'(coef);
               neg_ff   <= diff[16];
               state_ff <= S_SDIV;
            end
            S_SDIV: begin
               recip_ff <= 39'(mag_ff) * 39'(vumph_pkg::RECIP10);
               state_ff <= S_SAPPLY;
            end
            S_SAPPLY: begin
               level_ff <= level_new;
               if (level_new > peak_ff) begin
                  peak_ff  <= level_new;
                  hold_ff  <= 4'(HOLD_FRAMES);
                  state_ff <= S_OUT;
               end else if (hold_ff != '0) begin
                  hold_ff  <= hold_ff - 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_PDEC;
               end
            end
            S_PDEC: begin
               peak_ff  <= peak_prod[31:16];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> (rem_ff < gain_ff) && (gain_ff >= vumph_pkg::GAIN_FLOOR))
      else $error("divider remainder out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/vumph_column.sv =====
`default_nettype none

module vumph_column #(
   parameter int MAX_COLUMN = 21
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [7:0]                  full,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire vumph_pkg::level_pair_type   in_pair,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [5:0]                       rsp_column,
   output logic                             rsp_write_enable,
   output logic [7:0]                       rsp_red,
   output logic [7:0]                       rsp_green,
   output logic [7:0]                       rsp_blue,
   output logic                             rsp_last
);

   localparam int POS_W = $clog2(vumph_pkg::ONE_Q * MAX_COLUMN + 1);
   localparam logic [POS_W-1:0] POS_STEP = POS_W'(vumph_pkg::ONE_Q);
   localparam logic [POS_W-1:0] WIN      =
      POS_W'((6 * vumph_pkg::ONE_Q * MAX_COLUMN + 99) / 100);
   localparam logic [5:0]       LAST_COL = 6'(MAX_COLUMN);
   localparam logic [8:0]       GREEN_LIM  = 9'(MAX_COLUMN);
   localparam logic [9:0]       YELLOW_LIM = 10'(7 * MAX_COLUMN);

   typedef enum logic {C_IDLE, C_RUN} state_type;

   state_type         state_ff;
   logic [POS_W-1:0]  level_m_ff;
   logic [POS_W-1:0]  peak_m_ff;
   logic              peak_big_ff;
   logic [POS_W-1:0]  posn_ff;
   logic [5:0]        col_ff;
   logic              rsp_valid_ff;
   logic [5:0]        column_ff;
   logic              we_ff;
   logic [7:0]        red_ff;
   logic [7:0]        green_ff;
   logic              last_ff;

   logic              lit;
   logic              green_zone;
   logic              yellow_zone;
   logic [POS_W-1:0]  peak_dist;
   logic              near;
   logic              advance;

   assign lit         = (posn_ff <= level_m_ff);
   assign green_zone  = ((9'(col_ff) * 9'd5) < GREEN_LIM);
   assign yellow_zone = ((10'(col_ff) * 10'd10) < YELLOW_LIM);
   assign peak_dist   = (posn_ff >= peak_m_ff) ? (posn_ff - peak_m_ff)
                                               : (peak_m_ff - posn_ff);
   assign near        = (peak_dist < WIN) && peak_big_ff;
   assign advance     = (state_ff == C_RUN) && (!rsp_valid_ff || rsp_ready);

   assign in_ready         = (state_ff == C_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column       = column_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = 8'h00;
   assign rsp_last         = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            C_IDLE: begin
               if (in_valid) begin
                  level_m_ff  <= POS_W'(in_pair.level) * POS_W'(MAX_COLUMN);
                  peak_m_ff   <= POS_W'(in_pair.peak) * POS_W'(MAX_COLUMN);
                  peak_big_ff <= ((21'(in_pair.peak) * 21'd20) > 21'(vumph_pkg::ONE_Q));
                  posn_ff     <= '0;
                  col_ff      <= '0;
                  state_ff    <= C_RUN;
               end
            end
            C_RUN: begin
               if (advance) begin
                  column_ff    <= col_ff;
                  we_ff        <= lit || near;
                  red_ff       <= ((lit && !green_zone) || (!lit && near)) ? full : 8'h00;
                  green_ff     <= (lit && yellow_zone) ? full : 8'h00;
                  last_ff      <= (col_ff == LAST_COL);
                  if (col_ff == LAST_COL) begin
                     state_ff <= C_IDLE;
                  end else begin
                     col_ff  <= col_ff + 1'b1;
                     posn_ff <= posn_ff + POS_STEP;
                  end
               end
            end
            default: begin
               state_ff <= C_IDLE;
            end
         endcase
      end
   end

   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> column_ff == LAST_COL)
      else $error("last flag on wrong column");

   a_dark_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !we_ff |-> (red_ff == 8'h00) && (green_ff == 8'h00))
      else $error("unwritten column carries colour");

   a_col_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !last_ff |=>
         rsp_valid_ff && (column_ff == $past(column_ff) + 6'd1))
      else $error("column sequence broken");

endmodule

`default_nettype wire

// ===== hw/rtl/vu_meter_agc_peak_hold_unit.sv =====
// path: a frame passes the queue, then the level engine states S_GAIN, S_DIV, S_SMUL, S_SDIV,
// S_SAPPLY, S_PDEC when the bar peak decays, and S_OUT; S_DIV is skipped once energy reaches
// the gain peak; the column engine then registers each column result
// throughput: engines overlap, columns one per cycle while rsp_ready is high
// reset: synchronous, clears the queue, gain peak, level, bar peak and hold count,
// speed to 2 and brightness to 4
`default_nettype none

module vu_meter_agc_peak_hold_unit #(
   parameter int MAX_COLUMN  = 21,
   parameter int HOLD_FRAMES = 15
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_audio_present,
   input  wire logic [15:0]                    req_energy,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [5:0]                          rsp_column,
   output logic                                rsp_write_enable,
   output logic [7:0]                          rsp_red,
   output logic [7:0]                          rsp_green,
   output logic [7:0]                          rsp_blue,
   output logic                                rsp_last,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [vumph_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [2:0]                  speed_ff;
   logic [2:0]                  brightness_ff;
   logic                        csr_wr;
   logic [7:0]                  full;

   logic                        q_valid;
   logic                        q_ready;
   logic [15:0]                 q_energy;
   logic                        lv_valid;
   logic                        lv_ready;
   vumph_pkg::level_pair_type   lv_pair;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign full       = vumph_pkg::full_scale(brightness_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff      <= 3'd2;
         brightness_ff <= 3'd4;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            vumph_pkg::CSR_SPEED:  speed_ff      <= csr_pwdata[2:0];
            vumph_pkg::CSR_BRIGHT: brightness_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         vumph_pkg::CSR_SPEED:  csr_prdata = {29'b0, speed_ff};
         vumph_pkg::CSR_BRIGHT: csr_prdata = {29'b0, brightness_ff};
         default:               csr_prdata = '0;
      endcase
   end

   vumph_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_audio_present (req_audio_present),
      .req_energy        (req_energy),
      .out_valid         (q_valid),
      .out_ready         (q_ready),
      .out_energy        (q_energy)
   );

   vumph_level #(
      .HOLD_FRAMES (HOLD_FRAMES)
   ) u_level (
      .clock     (clock),
      .reset     (reset),
      .speed     (speed_ff),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_energy (q_energy),
      .out_valid (lv_valid),
      .out_ready (lv_ready),
      .out_pair  (lv_pair)
   );

   vumph_column #(
      .MAX_COLUMN (MAX_COLUMN)
   ) u_column (
      .clock            (clock),
      .reset            (reset),
      .full             (full),
      .in_valid         (lv_valid),
      .in_ready         (lv_ready),
      .in_pair          (lv_pair),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_column       (rsp_column),
      .rsp_write_enable (rsp_write_enable),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/sv/vu_meter_agc_peak_hold_unit_checker.sv =====
`timescale 1ns / 100ps

module vu_meter_agc_peak_hold_unit_checker #(
   parameter int MAX_COLUMN  = 21,
   parameter int HOLD_FRAMES = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_audio_present,
   input  logic [15:0]                  req_energy,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [5:0]                   rsp_column,
   input  logic                         rsp_write_enable,
   input  logic [7:0]                   rsp_red,
   input  logic [7:0]                   rsp_green,
   input  logic [7:0]                   rsp_blue,
   input  logic                         rsp_last,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [vumph_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   input  logic                         csr_pready,
   output int                           failures,
   output int                           pending,
   output int                           frames_seen,
   output int                           columns_seen,
   output int                           lit_seen,
   output int                           marks_seen
);
   import vumph_pkg::*;

   typedef struct packed {
      logic [5:0] column;
      logic       write_enable;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } column_paint_type;

   column_paint_type paint_q[$];
   logic [2:0]     speed_reg;
   logic [2:0]     bright_reg;
   logic [Q_W-1:0] gain_peak;
   logic [Q_W-1:0] level;
   logic [Q_W-1:0] bar_peak;
   logic [3:0]     hold_count;
   int             fail_n = 0;
   int             frame_n = 0;
   int             column_n = 0;
   int             lit_n = 0;
   int             mark_n = 0;

   // advance the meter by one frame and queue the colors of every column
   task automatic paint_frame(input logic present, input logic [15:0] energy);
      longint           t, g, n, diff, lv, fs, c, posn, peak_dist;
      logic [7:0]       full;
      column_paint_type p;
      t = present ? longint'(energy) : 0;
      g = (t > longint'(gain_peak)) ? t : longint'(gain_peak);
      g = (g * longint'(GAIN_DECAY_K)) >> 16;
      if (g < longint'(GAIN_FLOOR)) g = longint'(GAIN_FLOOR);
      gain_peak = Q_W'(g);
      n = (t * ONE_Q) / g;
      if (n > ONE_Q) n = ONE_Q;
      diff = n - longint'(level);
      lv = longint'(level) + (diff * (7 - longint'(speed_reg))) / 10;
      level = Q_W'(lv);
      if (level > bar_peak) begin
         bar_peak = level;
         hold_count = 4'(HOLD_FRAMES);
      end else if (hold_count > 0) begin
         hold_count = hold_count - 4'd1;
      end else begin
         bar_peak = Q_W'((longint'(bar_peak) * longint'(PEAK_DECAY_K)) >> 16);
      end
      fs = (255 * longint'(bright_reg)) / 4;
      if (fs > 255) fs = 255;
      full = 8'(fs);
      for (c = 0; c <= MAX_COLUMN; c++) begin
         posn = c * ONE_Q;
         p = '0;
         p.column = 6'(c);
         p.last = (c == MAX_COLUMN);
         if (posn <= longint'(level) * MAX_COLUMN) begin
            p.write_enable = 1'b1;
            lit_n++;
            // green, yellow and red zones
            if (5 * c < MAX_COLUMN) begin
               p.green = full;
            end else if (10 * c < 7 * MAX_COLUMN) begin
               p.red = full;
               p.green = full;
            end else begin
               p.red = full;
            end
         end else begin
            peak_dist = posn - longint'(bar_peak) * MAX_COLUMN;
            if (peak_dist < 0) peak_dist = -peak_dist;
            if (peak_dist * 100 < 6 * longint'(ONE_Q) * MAX_COLUMN &&
                longint'(bar_peak) * 20 > ONE_Q) begin
               p.write_enable = 1'b1;
               p.red = full;
               mark_n++;
            end
         end
         paint_q.push_back(p);
      end
      frame_n++;
   endtask

   task automatic check_field(input string field, input int col, input int want,
                              input int got);
      if (want != got) begin
         fail_n++;
         $display("%0t: column %0d %s expected %0d got %0d", $time, col, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      column_paint_type want;
      if (reset) begin
         speed_reg = 3'd2;
         bright_reg = 3'd4;
         gain_peak = '0;
         level = '0;
         bar_peak = '0;
         hold_count = '0;
         paint_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == CSR_SPEED) begin
               speed_reg = csr_pwdata[2:0];
            end else begin
               bright_reg = csr_pwdata[2:0];
            end
         end
         if (req_valid && req_ready) begin
            paint_frame(req_audio_present, req_energy);
         end
         if (rsp_valid && rsp_ready) begin
            if (paint_q.size() == 0) begin
               fail_n++;
               $display("%0t: column %0d arrived with nothing expected, expected none",
                        $time, rsp_column);
            end else begin
               want = paint_q.pop_front();
               column_n++;
               check_field("column", want.column, want.column, rsp_column);
               check_field("write_enable", want.column, want.write_enable, rsp_write_enable);
               check_field("red", want.column, want.red, rsp_red);
               check_field("green", want.column, want.green, rsp_green);
               check_field("blue", want.column, want.blue, rsp_blue);
               check_field("last", want.column, want.last, rsp_last);
            end
         end
      end
      failures     <= fail_n;
      pending      <= paint_q.size();
      frames_seen  <= frame_n;
      columns_seen <= column_n;
      lit_seen     <= lit_n;
      marks_seen   <= mark_n;
   end

endmodule

// ===== tb/sv/vu_meter_agc_peak_hold_unit_test.sv =====
`timescale 1ns / 100ps

module vu_meter_agc_peak_hold_unit_test;
   import vumph_pkg::*;

   localparam int MAX_COLUMN     = 21;
   localparam int HOLD_FRAMES    = 15;
   localparam int PHASES         = 8;
   localparam int SONG_FRAMES    = 50;
   localparam int SETTLE_CYCLES  = 40;
   localparam int RX_HOLD_CYCLES = 400;
   localparam int STALL_LIMIT    = 5000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_audio_present;
   logic [15:0]         req_energy;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [5:0]          rsp_column;
   logic                rsp_write_enable;
   logic [7:0]          rsp_red;
   logic [7:0]          rsp_green;
   logic [7:0]          rsp_blue;
   logic                rsp_last;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   int failures;
   int pending;
   int frames_seen;
   int columns_seen;
   int lit_seen;
   int marks_seen;

   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   bit rx_hold_request = 1'b0;

   vu_meter_agc_peak_hold_unit #(
      .MAX_COLUMN (MAX_COLUMN),
      .HOLD_FRAMES(HOLD_FRAMES)
   ) dut (.*);

   vu_meter_agc_peak_hold_unit_checker #(
      .MAX_COLUMN (MAX_COLUMN),
      .HOLD_FRAMES(HOLD_FRAMES)
   ) paint_check (.*);

   initial clock = 1'b0;
   always #1 clock = ~clock;

   task automatic csr_write(input logic index, input logic [2:0] value, input bit junk);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({index, 2'b00});
      csr_pwdata  <= {junk ? 29'($urandom) : 29'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input logic present, input logic [15:0] energy);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_audio_present <= present;
      req_energy        <= energy;
      do @(posedge clock); while (!req_ready);
   endtask

   // loud bursts, quiet runs often long enough for the hold to expire, and noise
   task automatic send_song(input int frames);
      int          left, run, kind;
      logic        present;
      logic [15:0] energy;
      left = frames;
      while (left > 0) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) run = $urandom_range(1, 8);
         else if (kind < 8) run = $urandom_range(10, 22);
         else run = $urandom_range(1, 5);
         if (run > left) run = left;
         left -= run;
         repeat (run) begin
            energy = 16'($urandom);
            if (kind < 4) begin
               present = 1'b1;
               energy = 16'($urandom_range(16384, 65535));
            end else if (kind < 8) begin
               present = ($urandom_range(0, 3) == 0);
               if (present) energy = 16'($urandom_range(0, 400));
            end else begin
               present = 1'($urandom);
            end
            send_frame(present, energy);
         end
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : receiver
      int wait_n;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rx_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
            rx_hold_request = 1'b0;
         end else begin
            wait_n = rx_idle_on ? $urandom_range(0, 8) : 0;
            if (wait_n > 0) begin
               rsp_ready <= 1'b0;
               repeat (wait_n) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("vu_meter_agc_peak_hold_unit_test: FAIL");
      $finish;
   end

   initial begin : stimulus
      int         phase;
      logic [2:0] spd;
      logic [2:0] bri;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_audio_present = 1'b0;
      req_energy        = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // silence, ignored energy, tiny energy against the gain floor,
      // saturation, odd bit patterns, then decay with the peak mark held
      send_frame(1'b0, 16'h0000);
      send_frame(1'b0, 16'hffff);
      send_frame(1'b1, 16'h0001);
      repeat (4) send_frame(1'b1, 16'hffff);
      send_frame(1'b1, 16'h00ff);
      send_frame(1'b1, 16'hff00);
      send_frame(1'b1, 16'h8000);
      repeat (12) send_frame(1'b1, 16'h0000);

      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: begin spd = 3'd0; bri = 3'd4; end
            1: begin spd = 3'd4; bri = 3'd0; end
            2: begin spd = 3'd7; bri = 3'd7; end
            3: begin spd = 3'd1; bri = 3'd1; end
            4: begin spd = 3'd3; bri = 3'd2; end
            5: begin spd = 3'd5; bri = 3'd3; end
            default: begin
               spd = 3'($urandom_range(0, 7));
               bri = 3'($urandom_range(0, 7));
            end
         endcase
         csr_write(CSR_SPEED, spd, phase >= 4);
         csr_write(CSR_BRIGHT, bri, phase >= 4);
         tx_idle_on = (phase % 3) != 1;
         rx_idle_on = (phase % 4) != 1;
         if (phase == 2) rx_hold_request = 1'b1;
         send_song(SONG_FRAMES);
      end
      settle();

      $display("covered %0d frames and %0d column results, %0d lit and %0d peak marks",
               frames_seen, columns_seen, lit_seen, marks_seen);
      $display("speed and brightness swept 0, 4, 7 and random values under idle and stall");
      if (failures == 0 && pending == 0) begin
         $display("vu_meter_agc_peak_hold_unit_test: PASS");
      end else begin
         $display("vu_meter_agc_peak_hold_unit_test: FAIL");
      end
      $finish;
   end

endmodule
